@@ design/mgc_pkg.sv @@
// Shared widths, constants and register codes for the master gain / clip meter.
`default_nettype none
package mgc_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;   // input and output sample width
    localparam int GAIN_W   = 9;    // gain in 256ths
    localparam int MAG_W    = 32;   // |sample * gain|
    localparam int PEAK_W   = 24;   // channel peak
    localparam int HELD_W   = 15;   // held overall peak
    localparam int DIV_W    = 33;   // divider numerator / denominator
    localparam int QUO_W    = 9;    // divider quotient

    // Stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 128;

    localparam int SAMPLE_BITS_DEF = 24;

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 9'd256;
    localparam logic [HELD_W-1:0] FULL_SCALE = 15'd32767;
    // 32767 * 256: a product above this clips
    localparam logic [MAG_W-1:0]  CLIP_MAG   = 32'd8388352;

    // Configuration register indexes
    typedef enum logic {
        REG_MASTER_GAIN = 1'b0,
        REG_REDUCE      = 1'b1
    } t_cfg_idx;

endpackage
`default_nettype wire

@@ design/mgc_mul.sv @@
// Bit-serial shift-add multiplier: sample magnitude times gain, one gain bit per cycle.
`default_nettype none
module mgc_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mgc_pkg::SAMPLE_W-1:0] i_a,
    input  wire logic [mgc_pkg::GAIN_W-1:0]   i_b,
    output logic                             o_done,
    output logic [mgc_pkg::MAG_W-1:0]         o_prod
);
    import mgc_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic [MAG_W-1:0]  r_acc;
    logic [MAG_W-1:0]  r_a;
    logic [GAIN_W-1:0] r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    // one partial product per cycle, LSB of gain first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= '0;
                r_a    <= MAG_W'(i_a);
                r_b    <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= {r_a[MAG_W-2:0], 1'b0};
                r_b   <= {1'b0, r_b[GAIN_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

@@ design/mgc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the gain reduction.
`default_nettype none
module mgc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [mgc_pkg::DIV_W-1:0] i_num,
    input  wire logic [mgc_pkg::DIV_W-1:0] i_den,
    output logic                           o_done,
    output logic [mgc_pkg::QUO_W-1:0]      o_quo
);
    import mgc_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam int DS_W  = DIV_W + QUO_W - 1;

    logic [DIV_W-1:0] r_rem;
    logic [DS_W-1:0]  r_ds;
    logic [QUO_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             w_fit;

    // the quotient is known to stay below 2^QUO_W, so QUO_W steps suffice
    assign w_fit = DS_W'(r_rem) >= r_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_ds   <= {i_den, {(QUO_W-1){1'b0}}};
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= r_rem - r_ds[DIV_W-1:0];
                end
                r_q   <= {r_q[QUO_W-2:0], w_fit};
                r_ds  <= {1'b0, r_ds[DS_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
`default_nettype wire

@@ design/master_gain_clip_meter.sv @@
// Master output stage: gain, automatic clip reduction and block peak meter.
//
// Input stream: one request per stereo pair. tdata = left_in[23:0], right_in[47:24];
// tuser = first_in_block[0], meter_was_read[1]; tlast = last_in_block.
// Output stream: one request per pair with both scaled samples, the running gain,
// both channel peaks, the held overall peak and the sticky clip flag.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 master_gain, limited to 256 and copied into the running gain; 1 reduce_on_clip).
// Items are handled one at a time. Each channel takes one pass through
// the bit-serial multiplier (start, load, 9 bit steps), and a clipping channel
// with reduction on takes a further pass through the serial divider. A block's
// last pair also passes through the peak clamp states ST_ENDL and ST_ENDR.
// The next request is accepted once the result is registered and the sequencer
// is back in idle.
// The input is taken again as soon as the result sits in the output register,
// so a stalled receiver costs nothing until a second result is ready; then the
// block holds that result and the input stays not ready.
// Reset: gain 256, reduction off, peaks 1, held peak 0, clip flag 0, no result.
`default_nettype none
module master_gain_clip_meter #(
    parameter int SAMPLE_BITS = mgc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // config
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_idx,
    input  wire logic [mgc_pkg::GAIN_W-1:0]       i_cfg_data,
    // input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [mgc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // left_in, right_in
    input  wire logic [mgc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // first_in_block, meter_was_read
    input  wire logic                             s_axis_tlast,
    // output stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_left, out_right, gain_now, left_level, right_level, overall_peak, clip_seen
    output logic [mgc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import mgc_pkg::*;

    localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;
    localparam int PAD_W = OUT_TDATA_W - (2*SAMPLE_W + GAIN_W + 2*PEAK_W + HELD_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ENDL,
        ST_ENDR,
        ST_DONE
    } t_state;

    t_state r_state;

    logic        [GAIN_W-1:0]   r_gain;
    logic                       r_reduce;
    logic        [PEAK_W-1:0]   r_lpk;
    logic        [PEAK_W-1:0]   r_rpk;
    logic        [HELD_W-1:0]   r_held;
    logic                       r_clip;
    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_right;
    logic                       r_last;
    logic                       r_ch;
    logic signed [SAMPLE_W-1:0] r_out_l;
    logic signed [SAMPLE_W-1:0] r_out_r;
    logic                       r_mul_start;
    logic                       r_div_start;

    // output register
    logic                       r_mvalid;
    logic        [SAMPLE_W-1:0] r_o_left;
    logic        [SAMPLE_W-1:0] r_o_right;
    logic        [GAIN_W-1:0]   r_o_gain;
    logic        [PEAK_W-1:0]   r_o_lpk;
    logic        [PEAK_W-1:0]   r_o_rpk;
    logic        [HELD_W-1:0]   r_o_held;
    logic                       r_o_clip;

    logic signed [SAMPLE_W-1:0] w_samp;
    logic                       w_neg;
    logic        [SAMPLE_W-1:0] w_umag;
    logic                       w_mul_done;
    logic        [MAG_W-1:0]    w_mag;
    logic        [MAG_W:0]      w_round;
    logic        [PEAK_W-1:0]   w_m;
    logic        [PEAK_W-1:0]   w_peak;
    logic signed [SAMPLE_W-1:0] w_sout;
    logic signed [SAMPLE_W-1:0] w_cout;
    logic                       w_clips;
    logic        [DIV_W-1:0]    w_num;
    logic        [DIV_W-1:0]    w_den;
    logic                       w_div_done;
    logic        [QUO_W-1:0]    w_quo;
    logic        [PEAK_W-1:0]   w_cl_l;
    logic        [PEAK_W-1:0]   w_cl_r;
    t_state                     w_after_ch;

    // saturate to the SAMPLE_BITS range, then keep 24 bits
    function automatic logic [SAMPLE_W-1:0] sat_out(input logic signed [SAMPLE_W-1:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        if (w > SAT_HI) begin
            w = SAT_HI;
        end else if (w < SAT_LO) begin
            w = SAT_LO;
        end
        return w[SAMPLE_W-1:0];
    endfunction

    // block-end peak clamp to 1..32767
    function automatic logic [PEAK_W-1:0] clamp_pk(input logic [PEAK_W-1:0] p);
        if (p > PEAK_W'(FULL_SCALE)) begin
            return PEAK_W'(FULL_SCALE);
        end else if (p == '0) begin
            return PEAK_W'(1);
        end
        return p;
    endfunction

    // current channel operand
    assign w_samp = r_ch ? r_right : r_left;
    assign w_neg  = w_samp[SAMPLE_W-1];
    assign w_umag = w_neg ? SAMPLE_W'(-w_samp) : SAMPLE_W'(w_samp);
    assign w_peak = r_ch ? r_rpk : r_lpk;

    mgc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (w_umag),
        .i_b     (r_gain),
        .o_done  (w_mul_done),
        .o_prod  (w_mag)
    );

    // rounded magnitude and candidate outputs
    assign w_round = {1'b0, w_mag} + (MAG_W+1)'(128);
    assign w_m     = w_round[PEAK_W+7:8];
    assign w_sout  = w_neg ? -$signed(w_m) : $signed(w_m);
    assign w_cout  = w_neg ? -SAMPLE_W'(signed'({1'b0, FULL_SCALE}))
                           : SAMPLE_W'(signed'({1'b0, FULL_SCALE}));
    assign w_clips = r_reduce && (w_mag > CLIP_MAG);

    // numerator gain*32767*512 + mag, denominator 2*mag
    assign w_num = DIV_W'({r_gain, 24'b0}) - DIV_W'({r_gain, 9'b0}) + DIV_W'(w_mag);
    assign w_den = {w_mag, 1'b0};

    mgc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_cl_l     = clamp_pk(r_lpk);
    assign w_cl_r     = clamp_pk(r_rpk);
    assign w_after_ch = r_last ? ST_ENDL : ST_DONE;

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gain      <= GAIN_ONE;
            r_reduce    <= 1'b0;
            r_lpk       <= PEAK_W'(1);
            r_rpk       <= PEAK_W'(1);
            r_held      <= '0;
            r_clip      <= 1'b0;
            r_ch        <= 1'b0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_mvalid    <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end

            // config writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    REG_MASTER_GAIN: begin
                        r_gain <= (i_cfg_data > GAIN_ONE) ? GAIN_ONE : i_cfg_data;
                    end
                    REG_REDUCE: begin
                        r_reduce <= i_cfg_data[0];
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_left      <= s_axis_tdata[SAMPLE_W-1:0];
                        r_right     <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
                        r_last      <= s_axis_tlast;
                        r_ch        <= 1'b0;
                        r_mul_start <= 1'b1;
                        r_state     <= ST_MUL;
                        // meter read: halve both peaks at block start
                        if (s_axis_tuser[0] && s_axis_tuser[1]) begin
                            r_lpk <= r_lpk >> 1;
                            r_rpk <= r_rpk >> 1;
                        end
                    end
                end
                ST_MUL: begin
                    if (w_mul_done) begin
                        if (w_m > w_peak) begin
                            if (r_ch) begin
                                r_rpk <= w_m;
                            end else begin
                                r_lpk <= w_m;
                            end
                        end
                        if (w_clips) begin
                            if (r_ch) begin
                                r_out_r <= w_cout;
                            end else begin
                                r_out_l <= w_cout;
                            end
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIV;
                        end else begin
                            if (r_ch) begin
                                r_out_r <= w_sout;
                                r_state <= w_after_ch;
                            end else begin
                                r_out_l     <= w_sout;
                                r_ch        <= 1'b1;
                                r_mul_start <= 1'b1;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_gain <= (w_quo > QUO_W'(GAIN_ONE)) ? GAIN_ONE : GAIN_W'(w_quo);
                        if (r_ch) begin
                            r_state <= w_after_ch;
                        end else begin
                            r_ch        <= 1'b1;
                            r_mul_start <= 1'b1;
                            r_state     <= ST_MUL;
                        end
                    end
                end
                ST_ENDL: begin
                    r_lpk <= w_cl_l;
                    if (r_lpk > PEAK_W'(FULL_SCALE)) begin
                        r_clip <= 1'b1;
                    end
                    if (w_cl_l > PEAK_W'(r_held)) begin
                        r_held <= w_cl_l[HELD_W-1:0];
                    end
                    r_state <= ST_ENDR;
                end
                ST_ENDR: begin
                    r_rpk <= w_cl_r;
                    if (r_rpk > PEAK_W'(FULL_SCALE)) begin
                        r_clip <= 1'b1;
                    end
                    if (w_cl_r > PEAK_W'(r_held)) begin
                        r_held <= w_cl_r[HELD_W-1:0];
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_o_left  <= sat_out(r_out_l);
                        r_o_right <= sat_out(r_out_r);
                        r_o_gain  <= r_gain;
                        r_o_lpk   <= r_lpk;
                        r_o_rpk   <= r_rpk;
                        r_o_held  <= r_held;
                        r_o_clip  <= r_clip;
                        r_mvalid  <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_o_clip, r_o_held, r_o_rpk, r_o_lpk,
                            r_o_gain, r_o_right, r_o_left};

endmodule
`default_nettype wire
